>>> rtl/smi2c_pkg.sv
// Shared types and constants of the shunt monitor register file.
package smi2c_pkg;

	localparam logic [7:0] REG_CONFIG = 8'h00;
	localparam logic [7:0] REG_SHUNT  = 8'h04;
	localparam logic [7:0] REG_BUS    = 8'h05;
	localparam int unsigned RANGE_BIT = 4;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_STOP  = 2'd3;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_WORD  = 2'd1;
	localparam logic [1:0] KIND_BUS   = 2'd2;
	localparam logic [1:0] KIND_SHUNT = 2'd3;

	localparam int unsigned NUM_W = 29;
	localparam int unsigned MUL_W = 30;
	localparam int unsigned QUO_W = 18;
	localparam int unsigned DIV_W = 13;

	localparam logic [DIV_W-1:0] DIV_BUS = 13'd6250;
	localparam logic [DIV_W-1:0] DIV_100 = 13'd100;
	localparam logic [DIV_W-1:0] DIV_50  = 13'd50;

	localparam logic [63:0] RECIP_BUS_64 = (64'd1 << 42) / 64'd6250;
	localparam logic [63:0] RECIP_100_64 = (64'd1 << 32) / 64'd100;
	localparam logic [63:0] RECIP_50_64  = (64'd1 << 32) / 64'd50;
	localparam logic [MUL_W-1:0] RECIP_BUS = RECIP_BUS_64[MUL_W-1:0];
	localparam logic [MUL_W-1:0] RECIP_100 = RECIP_100_64[MUL_W-1:0];
	localparam logic [MUL_W-1:0] RECIP_50  = RECIP_50_64[MUL_W-1:0];

	localparam int unsigned OUT_DEPTH = 4;

	typedef struct packed {
		logic [1:0]       kind;
		logic             ack;
		logic             sel;
		logic             neg;
		logic             rng;
		logic [NUM_W-1:0] num;
		logic [15:0]      word;
	} cmd_t;

	typedef struct packed {
		logic       ack;
		logic [7:0] read_byte;
	} res_t;

endpackage

>>> rtl/smi2c_front.sv
// Front end: bus event decode, register state and command queue.
module smi2c_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           action,
	input  logic [7:0]           write_byte,
	input  logic signed [27:0]   bus_voltage_uv,
	input  logic signed [21:0]   shunt_current_ma,
	input  logic                 device_present,
	output logic                 cmd_valid,
	output smi2c_pkg::cmd_t      cmd,
	input  logic                 cmd_take
);

	logic [7:0]  pointer_q;
	logic [1:0]  wr_idx_q;
	logic        rd_idx_q;
	logic [15:0] config_q;
	logic [15:0] pending_q;

	smi2c_pkg::cmd_t queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	smi2c_pkg::cmd_t new_cmd;
	logic            accept;
	logic [21:0]     ma_abs;

	assign full      = (count_q == 2'd2);
	assign accept    = push && !full;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];

	assign ma_abs = shunt_current_ma[21] ? (~shunt_current_ma + 22'd1) : shunt_current_ma;

	always_comb begin
		new_cmd      = '0;
		new_cmd.sel  = rd_idx_q;
		new_cmd.rng  = config_q[smi2c_pkg::RANGE_BIT];
		unique case (action)
			smi2c_pkg::ACT_START: begin
				new_cmd.kind = smi2c_pkg::KIND_NONE;
				new_cmd.ack  = device_present;
			end
			smi2c_pkg::ACT_WRITE: begin
				new_cmd.kind = smi2c_pkg::KIND_NONE;
				new_cmd.ack  = 1'b1;
			end
			smi2c_pkg::ACT_READ: begin
				priority if (pointer_q == smi2c_pkg::REG_CONFIG) begin
					new_cmd.kind = smi2c_pkg::KIND_WORD;
					new_cmd.word = config_q;
				end else if (pointer_q == smi2c_pkg::REG_BUS) begin
					if (!bus_voltage_uv[27] && (bus_voltage_uv != 28'sd0)) begin
						new_cmd.kind = smi2c_pkg::KIND_BUS;
						new_cmd.num  = {1'b0, bus_voltage_uv[26:0], 1'b0} + 29'd3125;
					end else begin
						new_cmd.kind = smi2c_pkg::KIND_WORD;
					end
				end else if (pointer_q == smi2c_pkg::REG_SHUNT) begin
					new_cmd.kind = smi2c_pkg::KIND_SHUNT;
					new_cmd.neg  = shunt_current_ma[21];
					if (config_q[smi2c_pkg::RANGE_BIT]) begin
						new_cmd.num = {5'd0, ma_abs, 2'b00} + 29'd25;
					end else begin
						new_cmd.num = {6'd0, ma_abs, 1'b0} + 29'd50;
					end
				end else begin
					new_cmd.kind = smi2c_pkg::KIND_WORD;
				end
			end
			smi2c_pkg::ACT_STOP: begin
				new_cmd.kind = smi2c_pkg::KIND_NONE;
			end
			default: begin
				new_cmd.kind = smi2c_pkg::KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_q <= '0;
			wr_idx_q  <= '0;
			rd_idx_q  <= 1'b0;
			config_q  <= '0;
			pending_q <= '0;
		end else if (accept) begin
			unique case (action)
				smi2c_pkg::ACT_WRITE: begin
					unique case (wr_idx_q)
						2'd0: pointer_q <= write_byte;
						2'd1: pending_q <= {write_byte, 8'h00};
						2'd2: begin
							pending_q <= {pending_q[15:8], write_byte};
							if (pointer_q == smi2c_pkg::REG_CONFIG) begin
								config_q <= {pending_q[15:8], write_byte};
							end
						end
						default: ;
					endcase
					if (wr_idx_q != 2'd3) begin
						wr_idx_q <= wr_idx_q + 2'd1;
					end
				end
				smi2c_pkg::ACT_READ: rd_idx_q <= ~rd_idx_q;
				default: begin
					wr_idx_q <= '0;
					rd_idx_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			queue_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, accept} - {1'b0, cmd_take};
		end
	end

endmodule

>>> rtl/smi2c_back.sv
// Back end: constant-divisor scaling, saturation, byte select and result queue.
module smi2c_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  smi2c_pkg::cmd_t cmd,
	output logic            cmd_take,
	output logic            empty,
	input  logic            pop,
	output logic            ack,
	output logic [7:0]      read_byte
);

	localparam int unsigned PTR_W = $clog2(smi2c_pkg::OUT_DEPTH);
	localparam int unsigned CNT_W = PTR_W + 1;

	logic                            v_s1;
	smi2c_pkg::cmd_t                 cmd_s1;
	logic [smi2c_pkg::QUO_W-1:0]     q0_s1;

	logic [smi2c_pkg::MUL_W-1:0]     recip;
	logic [smi2c_pkg::NUM_W+smi2c_pkg::MUL_W-1:0] prod;
	logic [smi2c_pkg::QUO_W-1:0]     q0;

	logic [smi2c_pkg::DIV_W-1:0]     div;
	logic [30:0]                     qd;
	logic [30:0]                     rem;
	logic [smi2c_pkg::QUO_W:0]       quo;
	logic [15:0]                     word;
	smi2c_pkg::res_t                 res;

	smi2c_pkg::res_t                 fifo_q [smi2c_pkg::OUT_DEPTH];
	logic [PTR_W-1:0]                wr_ptr_q;
	logic [PTR_W-1:0]                rd_ptr_q;
	logic [CNT_W-1:0]                count_q;
	logic                            do_pop;

	assign cmd_take = cmd_valid
		&& ((count_q + {{(CNT_W-1){1'b0}}, v_s1}) < CNT_W'(smi2c_pkg::OUT_DEPTH));

	always_comb begin
		priority if (cmd.kind == smi2c_pkg::KIND_BUS) begin
			recip = smi2c_pkg::RECIP_BUS;
		end else if (cmd.rng) begin
			recip = smi2c_pkg::RECIP_50;
		end else begin
			recip = smi2c_pkg::RECIP_100;
		end
	end

	assign prod = {{smi2c_pkg::MUL_W{1'b0}}, cmd.num} * {{smi2c_pkg::NUM_W{1'b0}}, recip};
	assign q0   = (cmd.kind == smi2c_pkg::KIND_BUS) ? {1'b0, prod[58:42]} : prod[49:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd_take;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_s1 <= cmd;
			q0_s1  <= q0;
		end
	end

	always_comb begin
		priority if (cmd_s1.kind == smi2c_pkg::KIND_BUS) begin
			div = smi2c_pkg::DIV_BUS;
		end else if (cmd_s1.rng) begin
			div = smi2c_pkg::DIV_50;
		end else begin
			div = smi2c_pkg::DIV_100;
		end
	end

	assign qd  = {13'd0, q0_s1} * {18'd0, div};
	assign rem = {2'b00, cmd_s1.num} - qd;
	assign quo = {1'b0, q0_s1} + {{smi2c_pkg::QUO_W{1'b0}}, (rem >= {18'd0, div})};

	always_comb begin
		unique case (cmd_s1.kind)
			smi2c_pkg::KIND_BUS: begin
				word = (quo > 19'd65535) ? 16'hFFFF : quo[15:0];
			end
			smi2c_pkg::KIND_SHUNT: begin
				if (cmd_s1.neg) begin
					word = (quo > 19'd32768) ? 16'h8000 : (~quo[15:0] + 16'd1);
				end else begin
					word = (quo > 19'd32767) ? 16'h7FFF : quo[15:0];
				end
			end
			smi2c_pkg::KIND_WORD: word = cmd_s1.word;
			default:              word = '0;
		endcase
	end

	always_comb begin
		res.ack = cmd_s1.ack;
		if (cmd_s1.kind == smi2c_pkg::KIND_NONE) begin
			res.read_byte = 8'h00;
		end else begin
			res.read_byte = cmd_s1.sel ? word[7:0] : word[15:8];
		end
	end

	assign empty     = (count_q == '0);
	assign do_pop    = pop && !empty;
	assign ack       = fifo_q[rd_ptr_q].ack;
	assign read_byte = fifo_q[rd_ptr_q].read_byte;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (v_s1) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + {{(CNT_W-1){1'b0}}, v_s1} - {{(CNT_W-1){1'b0}}, do_pop};
		end
	end

endmodule

>>> rtl/shunt_monitor_i2c_registers_core.sv
// A pushed word is registered in the front queue, then in stage 1, then in the result queue.
// Throughput: one word per cycle unless a queue fills; the front queue holds two commands, the result queue four.
// The scaling path is a reciprocal multiply stage followed by a one-step correction stage.
// Reset clears pointer, byte indexes, stored words and both queues; device_present resets to 1.
// Configuration is always ready and takes effect on the next start word.
module shunt_monitor_i2c_registers_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          action,
	input  logic [7:0]          write_byte,
	input  logic signed [27:0]  bus_voltage_uv,
	input  logic signed [21:0]  shunt_current_ma,
	output logic                empty,
	input  logic                pop,
	output logic                ack,
	output logic [7:0]          read_byte,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	logic            device_present_q;
	logic            cmd_valid;
	logic            cmd_take;
	smi2c_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_present_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			device_present_q <= cfg_data;
		end
	end

	smi2c_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.action           (action),
		.write_byte       (write_byte),
		.bus_voltage_uv   (bus_voltage_uv),
		.shunt_current_ma (shunt_current_ma),
		.device_present   (device_present_q),
		.cmd_valid        (cmd_valid),
		.cmd              (cmd),
		.cmd_take         (cmd_take)
	);

	smi2c_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.ack       (ack),
		.read_byte (read_byte)
	);

	a_take_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("command taken from empty queue");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> cmd_valid)
		else $error("accepted word missing from command queue");

	a_full_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> cmd_valid)
		else $error("queue full yet no command visible");

endmodule
